@@ hdl/tlvs_pkg.sv @@
// ----------------------------------------------------------------------------
// tlvs_pkg
// Shared types and constants for the TLV option search block.
// ----------------------------------------------------------------------------
package tlvs_pkg;

    localparam int BUF_BYTES = 4096;
    // offset counter must be able to hold BUF_BYTES itself (saturation value)
    localparam int OFFS_W    = $clog2(BUF_BYTES + 1);
    localparam int POS_W     = 12;

    localparam logic [1:0] ST_FOUND     = 2'd0;
    localparam logic [1:0] ST_END       = 2'd1;
    localparam logic [1:0] ST_EXHAUSTED = 2'd2;

    localparam logic [1:0] PH_TYPE = 2'd0;
    localparam logic [1:0] PH_LEN  = 2'd1;
    localparam logic [1:0] PH_DATA = 2'd2;

    localparam logic REG_TARGET = 1'b0;
    localparam logic REG_END    = 1'b1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [1:0]       status;
        logic [POS_W-1:0] position;
    } t_out_item;

    typedef struct packed {
        logic [7:0] target_type;
        logic [7:0] end_marker_type;
    } t_cfg;

endpackage

@@ hdl/tlvs_parse.sv @@
// ----------------------------------------------------------------------------
// tlvs_parse
// Option walker: parse state registers and the per-byte decision logic.
// ----------------------------------------------------------------------------
module tlvs_parse
    import tlvs_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_accept,
    input  t_in_item  i_item,
    input  t_cfg      i_cfg,
    output logic      o_res_valid,
    output t_out_item o_res
);

    logic [1:0]        r_phase,    n_phase;
    logic [OFFS_W-1:0] r_offset,   n_offset;
    logic [7:0]        r_skip,     n_skip;
    logic              r_answered, n_answered;

    logic              saturated;
    logic [7:0]        skip_dec;

    assign saturated = (r_offset >= OFFS_W'(BUF_BYTES));
    assign skip_dec  = (r_skip != 8'd0) ? r_skip - 8'd1 : r_skip;

    always_comb begin
        n_phase     = r_phase;
        n_offset    = r_offset;
        n_skip      = r_skip;
        n_answered  = r_answered;
        o_res_valid = 1'b0;
        o_res       = '{status: ST_EXHAUSTED, position: '0};

        if (!r_answered) begin
            if (saturated) begin
                o_res_valid = 1'b1;
                n_answered  = 1'b1;
            end else begin
                case (r_phase)
                    PH_TYPE: begin
                        // target compare wins over the end marker
                        if (i_item.data_byte == i_cfg.target_type) begin
                            o_res_valid = 1'b1;
                            o_res       = '{status: ST_FOUND,
                                            position: POS_W'(r_offset)};
                            n_answered  = 1'b1;
                        end else if (i_item.data_byte == i_cfg.end_marker_type) begin
                            o_res_valid = 1'b1;
                            o_res       = '{status: ST_END, position: '0};
                            n_answered  = 1'b1;
                        end else begin
                            n_phase = PH_LEN;
                        end
                    end
                    PH_LEN: begin
                        n_skip  = i_item.data_byte;
                        n_phase = (i_item.data_byte == 8'd0) ? PH_TYPE : PH_DATA;
                    end
                    default: begin
                        n_skip = skip_dec;
                        if (skip_dec == 8'd0) begin
                            n_phase = PH_TYPE;
                        end
                    end
                endcase
                n_offset = r_offset + OFFS_W'(1);
            end

            // truncated option or no hit at all
            if (!n_answered && i_item.last_byte) begin
                o_res_valid = 1'b1;
                o_res       = '{status: ST_EXHAUSTED, position: '0};
            end
        end

        if (i_item.last_byte) begin
            n_phase    = PH_TYPE;
            n_offset   = '0;
            n_skip     = '0;
            n_answered = 1'b0;
        end

        if (!i_accept) begin
            o_res_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_TYPE;
            r_offset   <= '0;
            r_skip     <= '0;
            r_answered <= 1'b0;
        end else if (i_accept) begin
            r_phase    <= n_phase;
            r_offset   <= n_offset;
            r_skip     <= n_skip;
            r_answered <= n_answered;
        end
    end

endmodule

@@ hdl/tlvs_out_buf.sv @@
// ----------------------------------------------------------------------------
// tlvs_out_buf
// Two-entry result buffer; decouples the parser from receiver stalls.
// ----------------------------------------------------------------------------
module tlvs_out_buf
    import tlvs_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_out_item i_push_data,
    input  logic      i_pop_stall,
    output logic      o_valid,
    output t_out_item o_data,
    output logic      o_full
);

    t_out_item  r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       pop;

    assign o_valid = (r_cnt != 2'd0);
    assign o_full  = (r_cnt == 2'd2);
    assign o_data  = r_mem[r_rp];
    assign pop     = o_valid && !i_pop_stall;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            case ({i_push, pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

@@ hdl/tlv_option_search.sv @@
// ----------------------------------------------------------------------------
// tlv_option_search
// Searches a streamed TLV options buffer for a target option type.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_data) carries one buffer
//   byte per transfer, last_byte set on the final byte of a buffer.
//   Output channel (o_out_valid / i_out_stall / o_out_data) carries at most
//   one result per buffer: status (found / end marker / exhausted) and the
//   offset of the matching type byte.
//   Config channel (i_cfg_valid / o_cfg_ready / i_cfg_index / i_cfg_data)
//   sets target_type (index 0) and end_marker_type (index 1); always ready.
//   Throughput: one byte per cycle while o_in_stall is low. The parser
//   decides each byte in the cycle it is transferred; results are registered.
//   Results sit in a two-entry buffer, so input keeps flowing while one
//   result waits; o_in_stall rises only when both entries are held.
//   Reset (synchronous, active low) clears the parse state, the buffer and
//   both config registers to zero.
// ----------------------------------------------------------------------------
module tlv_option_search
    import tlvs_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data,
    input  logic      i_cfg_valid,
    output logic      o_cfg_ready,
    input  logic      i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    t_cfg      r_cfg;
    logic      in_acc;
    logic      res_valid;
    t_out_item res;

    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_TARGET: r_cfg.target_type     <= i_cfg_data;
                REG_END:    r_cfg.end_marker_type <= i_cfg_data;
                default:    r_cfg                 <= r_cfg;
            endcase
        end
    end

    tlvs_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_acc),
        .i_item      (i_in_data),
        .i_cfg       (r_cfg),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    tlvs_out_buf u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (res_valid),
        .i_push_data (res),
        .i_pop_stall (i_out_stall),
        .o_valid     (o_out_valid),
        .o_data      (o_out_data),
        .o_full      (o_in_stall)
    );

    a_res_needs_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> in_acc)
        else $error("result produced without an input transfer");

    a_pos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status != ST_FOUND) |-> o_out_data.position == '0)
        else $error("nonzero position on a non-found result");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && !o_in_stall))
        else $error("result buffer not empty after reset");

endmodule
